// ===== sv/ccs_pkg.sv =====
package ccs_pkg;

   // Configuration port types.
   typedef logic [0:0]  csr_addr_type;
   typedef logic [16:0] csr_data_type;

   // Register indexes.
   localparam csr_addr_type REG_INPUT_GAIN = 1'd0;
   localparam csr_addr_type REG_INTENSITY  = 1'd1;

   // Reset value of both Q1.16 registers (unity).
   localparam csr_data_type CSR_UNITY = 17'd65536;

   // Chase speed constants, Q12.20.
   localparam logic [31:0] SPEED_ONE   = 32'd1048576;
   localparam logic [31:0] SPEED_DECAY = 32'd1048471;
   localparam logic [31:0] SPEED_SUB   = 32'd10486;
   localparam logic [31:0] SPEED_FLOOR = 32'd367001600;
   localparam logic [31:0] SPEED_CAP   = 32'd2621440000;

   // Golden ratio fraction, 64 fraction bits.
   localparam logic [63:0] GOLD64 = 64'h9E3779B97F4A7C15;

endpackage

// ===== sv/console_channel_saturator_top.sv =====
// Throughput: one transaction at a time; req_ready returns only after the result is taken.
// The serial gain divider (one quotient bit per cycle) and the shared multiplier, 32x32 at
// the default FRAC_BITS, set how long a transaction takes; the multiplier runs both sine
// series and the final error feedback.
// Reset is synchronous and active high: registers return to unity, state to its start values.
module console_channel_saturator_top #(
   parameter int SAMPLE_BITS = 24,
   parameter int FRAC_BITS   = 28
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_sample,
   input  logic                          csr_we,
   input  ccs_pkg::csr_addr_type         csr_addr,
   input  ccs_pkg::csr_data_type         csr_wdata
);
   import ccs_pkg::*;

   localparam int W   = FRAC_BITS + 4;
   localparam int MW  = (W > 32) ? W : 32;
   localparam int PW  = 2 * MW;
   localparam int D   = FRAC_BITS - SAMPLE_BITS + 1;
   localparam int DP  = (D > 0) ? D : 0;
   localparam int DN  = (D < 0) ? -D : 0;
   localparam int XW  = W + DN + DP + 2;
   localparam int SW  = SAMPLE_BITS + W;
   localparam int CW  = $clog2(W);
   localparam int HSH = (DP > 0) ? DP - 1 : 0;

   localparam logic signed [W-1:0] ONE_F = W'(64'd1 << FRAC_BITS);
   localparam logic [63:0] OLD64 = ((GOLD64 >> (63 - FRAC_BITS)) + 64'd1) >> 1;
   localparam logic signed [W-1:0] OLD_C = W'(OLD64);
   localparam logic signed [W-1:0] NEW_C = ONE_F - OLD_C;
   localparam logic [PW-1:0] RND_HALF = PW'(64'd1 << (FRAC_BITS - 1));
   localparam logic signed [XW-1:0] QHALF = (DP > 0) ? XW'(64'd1 << HSH) : '0;
   localparam logic signed [XW-1:0] HI_LIM = XW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [XW-1:0] LO_LIM = -HI_LIM - XW'(1);
   localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

   // Taylor divisors 2k(2k+1) for k = 1..8 and their reciprocals.
   localparam logic [63:0] MW_ONE = 64'd1 << MW;
   localparam logic [8:0] SIN_DIV [0:7] = '{9'd6, 9'd20, 9'd42, 9'd72,
                                           9'd110, 9'd156, 9'd210, 9'd272};
   localparam logic [MW-1:0] RECIP [0:7] = '{
      MW'(MW_ONE / 64'd6),   MW'(MW_ONE / 64'd20),  MW'(MW_ONE / 64'd42),
      MW'(MW_ONE / 64'd72),  MW'(MW_ONE / 64'd110), MW'(MW_ONE / 64'd156),
      MW'(MW_ONE / 64'd210), MW'(MW_ONE / 64'd272)};

   typedef enum logic [4:0] {
      ST_IDLE, ST_SPD_MUL, ST_SPD_FIN, ST_GDIV, ST_SMP_MUL, ST_SMP_RND,
      ST_SIN_SQ, ST_SIN_SQR, ST_SIN_TR, ST_SIN_Q1, ST_SIN_Q2, ST_SIN_Q3,
      ST_SIN_OUT, ST_SIN_END, ST_BL_MUL, ST_BL_A, ST_BL_V, ST_ER1, ST_ER2, ST_DONE
   } state_type;

   function automatic logic [W-1:0] magw(input logic signed [W-1:0] v);
      magw = v[W-1] ? W'(-v) : W'(v);
   endfunction

   // Rounds to the sample grid, nearest with ties toward +inf.
   function automatic logic signed [XW-1:0] quant(input logic signed [W:0] v);
      logic signed [XW-1:0] e;
      e = XW'(v);
      quant = ((e + QHALF) >>> DP) <<< DN;
   endfunction

   // Sample grid back to the fine grid.
   function automatic logic signed [XW-1:0] to_fine(input logic signed [XW-1:0] q);
      to_fine = (q <<< DP) >>> DN;
   endfunction

   state_type state_ff, state_in;
   logic [16:0] in_gain_ff, in_gain_in, intensity_ff, intensity_in;
   logic signed [W-1:0] gain_ff, gain_in, prev_ff, prev_in;
   logic signed [W-1:0] erre_ff, erre_in, erro_ff, erro_in;
   logic started_ff, started_in, pend_ff, pend_in, even_ff, even_in;
   logic [31:0] speed_ff, speed_in;
   logic signed [SAMPLE_BITS-1:0] smp_ff, smp_in, out_ff, out_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic neg_ff, neg_in;
   logic [32:0] den_ff, den_in;
   logic [33:0] rem_ff, rem_in;
   logic [W-1:0] quo_ff, quo_in;
   logic dneg_ff, dneg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic signed [W-1:0] t_ff, t_in, t2_ff, t2_in, r_ff, r_in;
   logic [2:0] km1_ff, km1_in;
   logic [W-1:0] nmag_ff, nmag_in;
   logic nneg_ff, nneg_in, sel_ff, sel_in;
   logic [MW-1:0] q0_ff, q0_in;
   logic signed [W-1:0] x_ff, x_in, y_ff, y_in, v_ff, v_in, t1_ff, t1_in;

   // Shared multiplier operands.
   logic [MW-1:0] mul_a, mul_b;
   logic mul_neg;

   // Rounded signed result of the previous product.
   logic [PW-1:0] rnd_sum;
   logic [W-1:0] rnd_mag;
   logic signed [W-1:0] rnd_val;
   assign rnd_sum = prod_ff + RND_HALF;
   assign rnd_mag = rnd_sum[FRAC_BITS +: W];
   assign rnd_val = neg_ff ? -$signed(rnd_mag) : $signed(rnd_mag);

   logic signed [W-1:0] target, fine_smp;
   logic signed [SW-1:0] fine_wide;
   assign target = $signed(W'({in_gain_ff, (FRAC_BITS - 16)'(0)}));
   assign fine_wide = ($signed(SW'(smp_ff)) <<< DP) >>> DN;
   assign fine_smp = fine_wide[W-1:0];

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_out_sample = out_ff;

   // Next-state and datapath selection.
   always_comb begin
      logic [32:0] sp2;
      logic [31:0] spc, sp, spn;
      logic signed [W-1:0] diff, dyx, acc, accn, qs, err_v;
      logic [W-1:0] dm, rem_c, q_c;
      logic [33:0] rem_sh;
      logic ge;
      logic signed [W:0] pys, vsum;
      logic [W:0] pym;
      logic signed [XW-1:0] qv, res;

      state_in = state_ff;
      in_gain_in = in_gain_ff;
      intensity_in = intensity_ff;
      gain_in = gain_ff;
      prev_in = prev_ff;
      erre_in = erre_ff;
      erro_in = erro_ff;
      started_in = started_ff;
      pend_in = pend_ff;
      even_in = even_ff;
      speed_in = speed_ff;
      smp_in = smp_ff;
      out_in = out_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dneg_in = dneg_ff;
      cnt_in = cnt_ff;
      t_in = t_ff;
      t2_in = t2_ff;
      r_in = r_ff;
      km1_in = km1_ff;
      nmag_in = nmag_ff;
      nneg_in = nneg_ff;
      sel_in = sel_ff;
      q0_in = q0_ff;
      x_in = x_ff;
      y_in = y_ff;
      v_in = v_ff;
      t1_in = t1_ff;
      mul_a = '0;
      mul_b = '0;
      mul_neg = 1'b0;

      sp2 = pend_ff ? {speed_ff, 1'b0} : {1'b0, speed_ff};
      spc = (sp2 > {1'b0, SPEED_CAP}) ? SPEED_CAP : sp2[31:0];
      sp = prod_ff[51:20];
      spn = (sp > SPEED_SUB) ? sp - SPEED_SUB : 32'd0;
      if (spn < SPEED_FLOOR) begin
         spn = SPEED_FLOOR;
      end
      diff = target - gain_ff;
      dm = magw(diff);
      rem_sh = {rem_ff[32:0], quo_ff[W-1]};
      ge = (rem_sh >= {1'b0, den_ff});
      rem_c = nmag_ff - prod_ff[W-1:0];
      q_c = W'(q0_ff) + W'(rem_c >= W'(SIN_DIV[km1_ff]));
      qs = nneg_ff ? -$signed(q_c) : $signed(q_c);
      pys = {prev_ff[W-1], prev_ff} + {y_ff[W-1], y_ff};
      pym = pys[W] ? (W+1)'(-pys) : (W+1)'(pys);
      dyx = y_ff - x_ff;
      acc = even_ff ? erre_ff : erro_ff;
      qv = quant({v_ff[W-1], v_ff});
      err_v = v_ff - W'(to_fine(qv));
      accn = t1_ff + rnd_val;
      vsum = {v_ff[W-1], v_ff} + {accn[W-1], accn};
      res = quant(vsum);
      if (res > HI_LIM) begin
         res = HI_LIM;
      end
      if (res < LO_LIM) begin
         res = LO_LIM;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               smp_in = req_sample;
               if (!started_ff) begin
                  gain_in = target;
                  started_in = 1'b1;
               end
               state_in = ST_SPD_MUL;
            end
         end
         ST_SPD_MUL: begin
            mul_a = MW'(spc);
            mul_b = MW'(SPEED_DECAY);
            pend_in = 1'b0;
            state_in = ST_SPD_FIN;
         end
         ST_SPD_FIN: begin
            speed_in = spn;
            den_in = {1'b0, spn} + {1'b0, SPEED_ONE};
            rem_in = 34'(dm[W-1 -: 20]);
            quo_in = {dm[W-21:0], 20'b0};
            dneg_in = diff[W-1];
            cnt_in = '0;
            state_in = ST_GDIV;
         end
         ST_GDIV: begin
            rem_in = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
            quo_in = {quo_ff[W-2:0], ge};
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CNT_LAST) begin
               gain_in = dneg_ff ? gain_ff - $signed(quo_in) : gain_ff + $signed(quo_in);
               state_in = ST_SMP_MUL;
            end
         end
         ST_SMP_MUL: begin
            mul_a = MW'(magw(fine_smp));
            mul_b = MW'(magw(gain_ff));
            mul_neg = fine_smp[W-1] ^ gain_ff[W-1];
            state_in = ST_SMP_RND;
         end
         ST_SMP_RND: begin
            t_in = rnd_val;
            sel_in = 1'b0;
            state_in = ST_SIN_SQ;
         end
         ST_SIN_SQ: begin
            mul_a = MW'(magw(t_ff));
            mul_b = MW'(magw(t_ff));
            state_in = ST_SIN_SQR;
         end
         ST_SIN_SQR: begin
            t2_in = rnd_val;
            r_in = ONE_F;
            km1_in = 3'd7;
            state_in = ST_SIN_TR;
         end
         ST_SIN_TR: begin
            mul_a = MW'(magw(t2_ff));
            mul_b = MW'(magw(r_ff));
            mul_neg = t2_ff[W-1] ^ r_ff[W-1];
            state_in = ST_SIN_Q1;
         end
         ST_SIN_Q1: begin
            // Quotient estimate by reciprocal; low by at most one.
            nmag_in = rnd_mag;
            nneg_in = neg_ff;
            mul_a = MW'(rnd_mag);
            mul_b = RECIP[km1_ff];
            state_in = ST_SIN_Q2;
         end
         ST_SIN_Q2: begin
            q0_in = prod_ff[PW-1:MW];
            mul_a = prod_ff[PW-1:MW];
            mul_b = MW'(SIN_DIV[km1_ff]);
            state_in = ST_SIN_Q3;
         end
         ST_SIN_Q3: begin
            r_in = ONE_F - qs;
            km1_in = km1_ff - 3'd1;
            state_in = (km1_ff == 3'd0) ? ST_SIN_OUT : ST_SIN_TR;
         end
         ST_SIN_OUT: begin
            mul_a = MW'(magw(t_ff));
            mul_b = MW'(magw(r_ff));
            mul_neg = t_ff[W-1] ^ r_ff[W-1];
            state_in = ST_SIN_END;
         end
         ST_SIN_END: begin
            if (!sel_ff) begin
               x_in = rnd_val;
               t_in = rnd_val;
               sel_in = 1'b1;
               state_in = ST_SIN_SQ;
            end else begin
               y_in = rnd_val;
               state_in = ST_BL_MUL;
            end
         end
         ST_BL_MUL: begin
            mul_a = MW'(pym[W:1]);
            mul_b = MW'(intensity_ff);
            prev_in = y_ff;
            state_in = ST_BL_A;
         end
         ST_BL_A: begin
            mul_a = MW'(magw(dyx));
            mul_b = MW'(prod_ff[16 +: W]);
            mul_neg = dyx[W-1];
            state_in = ST_BL_V;
         end
         ST_BL_V: begin
            v_in = x_ff + rnd_val;
            mul_a = MW'(magw(acc));
            mul_b = MW'(OLD_C);
            mul_neg = acc[W-1];
            state_in = ST_ER1;
         end
         ST_ER1: begin
            t1_in = rnd_val;
            mul_a = MW'(magw(err_v));
            mul_b = MW'(NEW_C);
            mul_neg = err_v[W-1];
            state_in = ST_ER2;
         end
         ST_ER2: begin
            if (even_ff) begin
               erre_in = accn;
            end else begin
               erro_in = accn;
            end
            even_in = !even_ff;
            out_in = res[SAMPLE_BITS-1:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register writes; a changed gain restarts the fast chase.
      if (csr_we) begin
         case (csr_addr)
            REG_INPUT_GAIN: begin
               if (csr_wdata != in_gain_ff) begin
                  pend_in = 1'b1;
               end
               in_gain_in = csr_wdata;
            end
            REG_INTENSITY: begin
               intensity_in = csr_wdata;
            end
            default: begin
               in_gain_in = in_gain_ff;
            end
         endcase
      end

      prod_in = PW'(mul_a) * PW'(mul_b);
      neg_in = mul_neg;
   end

   // State and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         in_gain_ff <= CSR_UNITY;
         intensity_ff <= CSR_UNITY;
         gain_ff <= '0;
         prev_ff <= '0;
         erre_ff <= '0;
         erro_ff <= '0;
         started_ff <= 1'b0;
         pend_ff <= 1'b1;
         even_ff <= 1'b1;
         speed_ff <= SPEED_FLOOR;
      end else begin
         state_ff <= state_in;
         in_gain_ff <= in_gain_in;
         intensity_ff <= intensity_in;
         gain_ff <= gain_in;
         prev_ff <= prev_in;
         erre_ff <= erre_in;
         erro_ff <= erro_in;
         started_ff <= started_in;
         pend_ff <= pend_in;
         even_ff <= even_in;
         speed_ff <= speed_in;
      end
      smp_ff <= smp_in;
      out_ff <= out_in;
      prod_ff <= prod_in;
      neg_ff <= neg_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dneg_ff <= dneg_in;
      cnt_ff <= cnt_in;
      t_ff <= t_in;
      t2_ff <= t2_in;
      r_ff <= r_in;
      km1_ff <= km1_in;
      nmag_ff <= nmag_in;
      nneg_ff <= nneg_in;
      sel_ff <= sel_in;
      q0_ff <= q0_in;
      x_ff <= x_in;
      y_ff <= y_in;
      v_ff <= v_in;
      t1_ff <= t1_in;
   end

   // The block holds one transaction at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while a result is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!req_ready && !rsp_valid))
      else $error("sequencer did not start after a transaction");

   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      (speed_ff >= SPEED_FLOOR) && (speed_ff <= SPEED_CAP))
      else $error("chase speed out of range");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import ccs_pkg::*;

   localparam int SB = 24;
   localparam int FB = 28;
   localparam longint ONE_Q = 64'sd1 << FB;
   localparam int STALL_LIMIT = 6000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [SB-1:0] req_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [SB-1:0] rsp_out_sample;
   logic                 csr_we = 1'b0;
   csr_addr_type         csr_addr = REG_INPUT_GAIN;
   csr_data_type         csr_wdata = '0;

   console_channel_saturator_top uut (.*);

   always #5 clock = ~clock;

   // Shadow registers and the saturator state as the predictor sees them.
   longint unsigned trim_target, blend_depth, chase_rate;
   longint          trim_gain, last_shaped, fb_even, fb_odd;
   bit              trim_loaded, rate_boost, even_turn;

   logic signed [SB-1:0] pending_samples[$];
   int mismatches = 0;
   int checked = 0;
   int idle_cycles = 0;
   int gap_mode = 0;
   int stall_mode = 0;

   function automatic longint unsigned mag64(longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   // Q28 product on magnitudes, rounded half away from zero.
   function automatic longint qmul(longint a, longint b);
      bit [127:0] p;
      longint     r;
      p = 128'(mag64(a)) * 128'(mag64(b)) + (128'd1 << (FB - 1));
      r = longint'(p[FB +: 64]);
      return ((a < 0) != (b < 0)) ? -r : r;
   endfunction

   // Taylor sine through the 17th power, Horner form, truncating divides.
   function automatic longint qsin(longint t);
      longint t2, r;
      t2 = qmul(t, t);
      r = ONE_Q;
      for (int k = 8; k >= 1; k--) begin
         r = ONE_Q - qmul(t2, r) / longint'((2 * k) * (2 * k + 1));
      end
      return qmul(t, r);
   endfunction

   // Fine value to the 24-bit grid, nearest with ties upward.
   function automatic longint to_grid(longint v);
      return (v + (64'sd1 << (FB - SB))) >>> (FB - SB + 1);
   endfunction

   task automatic reset_state();
      trim_target = 65536;
      blend_depth = 65536;
      trim_gain = 0;
      trim_loaded = 0;
      chase_rate = SPEED_FLOOR;
      rate_boost = 1;
      last_shaped = 0;
      fb_even = 0;
      fb_odd = 0;
      even_turn = 1;
   endtask

   // Computes the saturated output sample and advances the predictor state.
   function automatic logic signed [SB-1:0] saturate_sample(logic signed [SB-1:0] smp);
      longint          target, gold_old, gold_new, diff, stp, s, x, y, a, v, q, err, acc, res;
      longint unsigned m;
      target = longint'(trim_target) <<< (FB - 16);
      gold_old = longint'(((GOLD64 >> (63 - FB)) + 1) >> 1);
      gold_new = ONE_Q - gold_old;
      if (rate_boost) begin
         chase_rate = chase_rate * 2;
         rate_boost = 0;
      end
      if (chase_rate > SPEED_CAP) chase_rate = SPEED_CAP;
      if (!trim_loaded) begin
         trim_gain = target;
         trim_loaded = 1;
      end
      chase_rate = (chase_rate * SPEED_DECAY) >> 20;
      chase_rate = chase_rate > SPEED_SUB ? chase_rate - SPEED_SUB : 0;
      if (chase_rate < SPEED_FLOOR) chase_rate = SPEED_FLOOR;
      diff = target - trim_gain;
      stp = longint'((mag64(diff) << 20) / (chase_rate + SPEED_ONE));
      trim_gain += diff < 0 ? -stp : stp;

      s = qmul(longint'(smp) <<< (FB - SB + 1), trim_gain);
      x = qsin(s);
      y = qsin(x);
      m = mag64(last_shaped + y) >> 1;
      a = longint'((m * blend_depth) >> 16);
      v = x + qmul(y - x, a);
      last_shaped = qsin(x);

      q = to_grid(v);
      err = v - (q <<< (FB - SB + 1));
      acc = even_turn ? fb_even : fb_odd;
      acc = qmul(acc, gold_old) + qmul(err, gold_new);
      if (even_turn) fb_even = acc;
      else fb_odd = acc;
      even_turn = !even_turn;
      res = to_grid(v + acc);
      if (res > 64'sd8388607) res = 64'sd8388607;
      if (res < -64'sd8388608) res = -64'sd8388608;
      return res[SB-1:0];
   endfunction

   // Prediction on every accepted request transaction.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) pending_samples.push_back(saturate_sample(req_sample));
   end

   // Result check against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         checked++;
         if (pending_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %0d", rsp_out_sample);
         end else begin
            if (rsp_out_sample !== pending_samples[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected %0d, got %0d", checked,
                           pending_samples[0], rsp_out_sample);
            end
            void'(pending_samples.pop_front());
         end
      end
   end

   // Receiver back-pressure: when stall_mode is set, often ready, sometimes long stalls.
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (stall_mode != 0 && $urandom_range(0, 99) < 25) begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog on cycles with no transaction.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("[console_channel_saturator_top] ERROR");
         $finish;
      end
   end

   task automatic send_sample(logic signed [SB-1:0] smp);
      int gap;
      int r;
      r = $urandom_range(0, 99);
      gap = 0;
      if (gap_mode != 0) gap = r < 60 ? 0 : (r < 90 ? $urandom_range(1, 3) : $urandom_range(5, 40));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= smp;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (FB + 100) @(posedge clock);
   endtask

   task automatic write_reg(csr_addr_type idx, csr_data_type val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_INPUT_GAIN) begin
         if (longint'(val) != trim_target) rate_boost = 1;
         trim_target = val;
      end else begin
         blend_depth = val;
      end
   endtask

   function automatic logic signed [SB-1:0] random_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return SB'($urandom());
      if (r < 8) return $signed(SB'($urandom_range(0, 8191))) - SB'(4096);
      return r == 8 ? 24'sh7FFFFF : 24'sh800000;
   endfunction

   typedef struct {
      logic signed [SB-1:0] smp;
      bit                   known;
      logic signed [SB-1:0] result;
   } stim_row_type;

   stim_row_type directed[] = '{
      '{24'sd0, 1, 24'sd0},
      '{24'sh7FFFFF, 0, 0}, '{24'sh800000, 0, 0}, '{24'sd1, 0, 0}, '{-24'sd1, 0, 0},
      '{24'sh555555, 0, 0}, '{24'shAAAAAA, 0, 0}, '{24'sh400000, 0, 0},
      '{-24'sh400000, 0, 0}, '{24'sd0, 0, 0}, '{24'sh7FFFFF, 0, 0}, '{24'sh800000, 0, 0}
   };

   csr_data_type gain_set[6] = '{17'd0, CSR_UNITY, 17'h1FFFF, 17'd32768, 17'd32768, 17'd12345};
   csr_data_type depth_set[6] = '{17'd0, CSR_UNITY, 17'h1FFFF, 17'd16384, 17'd0, 17'd50000};

   initial begin
      reset_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows at reset defaults; known rows are checked on their own too.
      foreach (directed[i]) begin
         send_sample(directed[i].smp);
         if (directed[i].known) begin
            req_valid <= 1'b0;
            wait (pending_samples.size() != 0);
            if (pending_samples[0] !== directed[i].result) begin
               mismatches++;
               $display("row %0d: expected %0d, predicted %0d", i, directed[i].result,
                        pending_samples[0]);
            end
         end
      end
      drain();

      // Phases over register settings, including extremes and an unchanged gain write.
      for (int p = 0; p < 6; p++) begin
         write_reg(REG_INPUT_GAIN, gain_set[p]);
         write_reg(REG_INTENSITY, depth_set[p]);
         gap_mode = p % 3;
         stall_mode = (p + 1) % 3;
         for (int n = 0; n < 300; n++) send_sample(random_sample());
         drain();
      end

      $display("Checked %0d output samples over six gain and intensity settings,", checked);
      $display("with random source gaps and receiver stalls.");
      if (mismatches == 0) $display("[console_channel_saturator_top] OK");
      else $display("[console_channel_saturator_top] ERROR");
      $finish;
   end
endmodule
